@@ rtl/core/breakpoint_table_assert.svh @@
// Assertion macros used by the breakpoint table datapath.
`ifndef BREAKPOINT_TABLE_ASSERT_SVH
`define BREAKPOINT_TABLE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BPT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define BPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bpt_pkg.sv @@
// Shared types and constants for the breakpoint table.
`timescale 1ns / 1ps

package bpt_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int ADDR_W          = 32;

  // Item kinds carried on the input tuser bit
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CHECK  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch the accepted word and restart the scan
    logic scan;   // issue a table read and advance the scan index
    logic apply;  // update the table and load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_read;  // scan index points at the final entry
    logic out_free;   // result register can take a new word
  } sts_t;

endpackage

@@ rtl/core/bpt_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bpt_ctrl.sv @@
// Sequencer for the breakpoint table: accept, scan, drain, apply.
`timescale 1ns / 1ps

module bpt_ctrl
  import bpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive handshake and datapath commands
  assign s_tready  = (state == ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && s_tvalid;
  assign cmd.scan  = (state == ST_SCAN);
  assign cmd.apply = (state == ST_APPLY) && sts.out_free;

endmodule

@@ rtl/core/bpt_datapath.sv @@
// Breakpoint table storage, scan compare, table update and result register.
`timescale 1ns / 1ps
`include "breakpoint_table_assert.svh"

module bpt_datapath
  import bpt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_enable,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic debug_en;

  // Latched item
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic              enable;

  // Scan state
  logic [IDX_W-1:0]  cnt;
  logic              cmp_pend;
  logic [IDX_W-1:0]  cmp_idx;
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // Table state
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_skip;
  logic [ADDR_W-1:0]  rdata;

  // Result register
  logic out_valid;
  logic out_hit;
  logic out_notify;
  logic out_state;
  logic out_full;

  logic is_check;
  logic do_toggle;
  logic do_hit;
  logic do_remove;
  logic do_insert;
  logic do_full;
  logic cmp_valid;
  logic cmp_match;

  // Address storage, read once per scan step
  bpt_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(ENTRIES)
  ) u_addr_ram (
    .clk  (clk),
    .we   (cmd.apply && do_insert),
    .waddr(free_idx),
    .wdata(address),
    .raddr(cnt),
    .rdata(rdata)
  );

  // Compare the entry read in the previous cycle
  assign cmp_valid = entry_valid[cmp_idx];
  assign cmp_match = cmp_pend && cmp_valid && (rdata == address);

  // Decide the outcome from the finished scan
  assign is_check  = (kind == KIND_CHECK);
  assign do_toggle = is_check && debug_en && match_found;
  assign do_hit    = do_toggle && !entry_skip[match_idx];
  assign do_remove = !is_check && !enable && match_found;
  assign do_insert = !is_check && enable && !match_found && free_found;
  assign do_full   = !is_check && enable && !match_found && !free_found;

  assign sts.last_read = (cnt == LAST_IDX);
  assign sts.out_free  = !out_valid || m_tready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      debug_en    <= 1'b0;
      cmp_pend    <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        debug_en <= cfg_wdata;
      end
      cmp_pend <= cmd.scan;
      if (cmd.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmp_pend) begin
        if (cmp_match) begin
          match_found <= 1'b1;
        end
        if (!cmp_valid) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.apply && do_remove) begin
        entry_valid[match_idx] <= 1'b0;
      end
      if (cmd.apply && do_insert) begin
        entry_valid[free_idx] <= 1'b1;
      end
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= in_kind;
      address <= in_address;
      enable  <= in_enable;
    end
    // Advance the read index through the table
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.scan && !sts.last_read) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.scan) begin
      cmp_idx <= cnt;
    end
    if (cmp_match) begin
      match_idx <= cmp_idx;
    end
    // Keep the lowest free entry
    if (cmp_pend && !cmp_valid && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.apply && do_toggle) begin
      entry_skip[match_idx] <= !entry_skip[match_idx];
    end
    if (cmd.apply && do_insert) begin
      entry_skip[free_idx] <= 1'b0;
    end
    if (cmd.apply) begin
      out_hit    <= do_hit;
      out_notify <= do_remove || do_insert;
      out_state  <= do_insert;
      out_full   <= do_full;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_full, out_state, out_notify, out_hit};

  `BPT_ASSERT_ALWAYS(a_one_outcome, !out_valid || !(out_hit && (out_notify || out_full)), "check result carries update flags")
  `BPT_ASSERT_ALWAYS(a_state_needs_notify, !out_valid || !out_state || out_notify, "notify_state set without notify")
  `BPT_ASSERT_NEXT(a_insert_valid, cmd.apply && do_insert, entry_valid[$past(free_idx)], "inserted entry not marked valid")

endmodule

@@ rtl/core/breakpoint_table.sv @@
// Top level of the breakpoint table: controller, datapath and port packing.
`timescale 1ns / 1ps

// Breakpoint table with a skip-once flag per entry. An update word
// (tuser 0) sets or clears the breakpoint at tdata[31:0] according to
// tdata[32]; a check word (tuser 1) looks the address up and, while
// debugging is enabled, toggles the skip flag of the matching entry and
// hits only if that flag was clear. Every input word yields exactly one
// result word. The lookup walks the table one entry per cycle through
// the single read port of the address RAM, followed by a final compare
// step and an update step. A new word is accepted only once the
// controller is back in idle after the update step, not while a word
// is still in the scan. The next word is accepted while a result still
// waits on the output side; its update step then stalls until the
// waiting result is taken.
// Occupancy flags sit in flip-flops cleared by reset, so there is no
// clearing pass. Write debug_enabled only while the block is idle.
module breakpoint_table
  import bpt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] address, [32] enable, [39:33] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] hit, [1] notify, [2] notify_state,
                                 // [3] table_full, [7:4] zero
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each word through the scan
  bpt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Hold the table and build results
  bpt_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_kind   (s_tuser),
    .in_address(s_tdata[ADDR_W-1:0]),
    .in_enable (s_tdata[ADDR_W]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
